// ----- hw/rtl/nsum_pkg.sv -----
`default_nettype none
package nsum_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int CFG_W        = 11;
    localparam int ROW_W        = 11;
    localparam int SUM_W        = 12;
    localparam int CFG_IDX_W    = 1;
    localparam int IN_DATA_W    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((SUM_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIXEL_BITS-1:0] t_pixel;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [SUM_W-1:0]      t_sum;

    // Per-item control carried from the position logic to the window stage.
    typedef struct packed {
        t_addr  addr;
        t_pixel pix;
        logic   out_en;
        logic   top;
        logic   bottom;
        logic   left;
        logic   right;
        logic   last;
    } t_item_ctrl;

endpackage
`default_nettype wire

// ----- hw/rtl/nsum_ctrl.sv -----
`default_nettype none
module nsum_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [nsum_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [nsum_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic                           i_s1_go,
    input  wire nsum_pkg::t_pixel               i_pix,
    output nsum_pkg::t_addr                     o_rd_addr,
    output logic                                o_s1_valid,
    output nsum_pkg::t_item_ctrl                o_s1
);
    import nsum_pkg::*;

    logic [CFG_W-1:0]  r_width_cfg;
    logic [CFG_W-1:0]  r_height_cfg;
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_s1_valid;
    t_item_ctrl        r_s1;

    logic [CFG_W-1:0]  w;
    logic [CFG_W-1:0]  h;
    logic [ADDR_W-1:0] col_adj;
    logic [ROW_W-1:0]  row_adj;
    logic [ADDR_W-1:0] ic;
    logic [ROW_W-1:0]  ir;
    logic              res_valid;
    logic [ROW_W-1:0]  r_pos;
    logic [CFG_W-1:0]  c_pos;
    logic              out_en;
    logic              last;
    logic [ADDR_W-1:0] n_col;
    logic [ROW_W-1:0]  n_row;
    t_item_ctrl        n_s1;

    always_comb begin
        if (r_width_cfg == '0) begin
            w = CFG_W'(1);
        end else if (r_width_cfg > CFG_W'(MAX_WIDTH)) begin
            w = CFG_W'(MAX_WIDTH);
        end else begin
            w = r_width_cfg;
        end
        if (r_height_cfg == '0) begin
            h = CFG_W'(1);
        end else if (r_height_cfg > CFG_W'(HEIGHT_LIMIT)) begin
            h = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h = r_height_cfg;
        end
    end

    always_comb begin
        // A narrowed width can leave the column past the row end.
        if (CFG_W'(r_col) >= w) begin
            col_adj = '0;
            row_adj = r_row + ROW_W'(1);
        end else begin
            col_adj = r_col;
            row_adj = r_row;
        end
        // Positions beyond the last flush position restart the frame.
        if (({1'b0, row_adj} > ({1'b0, h} + 12'd1)) ||
            (({1'b0, row_adj} == ({1'b0, h} + 12'd1)) && (col_adj != '0))) begin
            ic = '0;
            ir = '0;
        end else begin
            ic = col_adj;
            ir = row_adj;
        end

        res_valid = 1'b0;
        r_pos     = '0;
        c_pos     = '0;
        if (ic != '0) begin
            if (ir != '0) begin
                res_valid = 1'b1;
                r_pos     = ir - ROW_W'(1);
                c_pos     = CFG_W'(ic) - CFG_W'(1);
            end
        end else if (ir >= ROW_W'(2)) begin
            res_valid = 1'b1;
            r_pos     = ir - ROW_W'(2);
            c_pos     = w - CFG_W'(1);
        end
        out_en = res_valid && (r_pos < h);
        last   = (r_pos == h - CFG_W'(1)) && (c_pos == w - CFG_W'(1));

        if ((CFG_W'(ic) + CFG_W'(1)) >= w) begin
            n_col = '0;
            n_row = ir + ROW_W'(1);
        end else begin
            n_col = ic + ADDR_W'(1);
            n_row = ir;
        end
        if (out_en && last) begin
            n_col = '0;
            n_row = '0;
        end

        n_s1.addr   = ic;
        n_s1.pix    = i_pix;
        n_s1.out_en = out_en;
        n_s1.top    = r_pos != '0;
        n_s1.bottom = ({1'b0, r_pos} + 12'd1) < {1'b0, h};
        n_s1.left   = c_pos != '0;
        n_s1.right  = ({1'b0, c_pos} + 12'd1) < {1'b0, w};
        n_s1.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= CFG_W'(4);
            r_height_cfg <= CFG_W'(4);
            r_col        <= '0;
            r_row        <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_s1_valid <= 1'b1;
            end else if (i_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_rd_addr  = ic;
    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule
`default_nettype wire

// ----- hw/rtl/nsum_line_mem.sv -----
`default_nettype none
module nsum_line_mem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire nsum_pkg::t_addr   i_rd_addr,
    input  wire nsum_pkg::t_pixel  i_pix,
    input  wire logic              i_s1_valid,
    input  wire logic              i_s1_go,
    input  wire nsum_pkg::t_addr   i_s1_addr,
    output nsum_pkg::t_pixel       o_up,
    output nsum_pkg::t_pixel       o_mid
);
    import nsum_pkg::*;

    t_pixel mem_upper  [MAX_WIDTH];
    t_pixel mem_middle [MAX_WIDTH];
    t_pixel r_up_rd;
    t_pixel r_mid_rd;
    t_pixel r_fwd_data;
    logic   r_fwd_en;

    // The middle store is written with the new pixel on the read cycle and
    // returns the old entry. The upper store takes that old entry when the
    // item moves on; a read of the same entry in that cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_rd               <= mem_upper[i_rd_addr];
            r_mid_rd              <= mem_middle[i_rd_addr];
            mem_middle[i_rd_addr] <= i_pix;
            r_fwd_data            <= r_mid_rd;
        end
        if (i_s1_go) begin
            mem_upper[i_s1_addr] <= r_mid_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_en <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_en <= i_s1_valid && (i_s1_addr == i_rd_addr);
        end
    end

    assign o_up  = r_fwd_en ? r_fwd_data : r_up_rd;
    assign o_mid = r_mid_rd;

endmodule
`default_nettype wire

// ----- hw/rtl/nsum_window.sv -----
`default_nettype none
module nsum_window (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s1_go,
    input  wire nsum_pkg::t_item_ctrl i_s1,
    input  wire nsum_pkg::t_pixel     i_up,
    input  wire nsum_pkg::t_pixel     i_mid,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output nsum_pkg::t_sum            o_sum,
    output logic                      o_last
);
    import nsum_pkg::*;

    // Rows 0..2 of the two older window columns; the newest column is the
    // item in flight.
    t_pixel r_col0 [3];
    t_pixel r_col1 [3];
    t_pixel col2   [3];
    logic   r_out_valid;
    t_sum   r_sum;
    logic   r_last;
    t_sum   n_sum;
    logic   row_en [3];

    always_comb begin
        col2[0]   = i_up;
        col2[1]   = i_mid;
        col2[2]   = i_s1.pix;
        row_en[0] = i_s1.top;
        row_en[1] = 1'b1;
        row_en[2] = i_s1.bottom;
        n_sum     = '0;
        for (int k = 0; k < 3; k++) begin
            if (row_en[k]) begin
                if (i_s1.left) begin
                    n_sum = n_sum + SUM_W'(r_col0[k]);
                end
                n_sum = n_sum + SUM_W'(r_col1[k]);
                if (i_s1.right) begin
                    n_sum = n_sum + SUM_W'(col2[k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_col0[k] <= '0;
                r_col1[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_s1_go) begin
                for (int k = 0; k < 3; k++) begin
                    r_col0[k] <= r_col1[k];
                    r_col1[k] <= col2[k];
                end
            end
            if (i_s1_go && i_s1.out_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_go && i_s1.out_en) begin
            r_sum  <= n_sum;
            r_last <= i_s1.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sum       = r_sum;
    assign o_last      = r_last;

endmodule
`default_nettype wire

// ----- hw/rtl/neighbourhood_sum_3x3_top.sv -----
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------
// s_axis    | in        | tvalid / tready     | tdata: pixel; tuser: is_drain
// m_axis    | out       | tvalid / tready     | tdata: window_sum; tlast: last
// cfg       | in        | valid / ready       | index 0 image_width, 1 image_height
//
// One pixel per clock is accepted unless the output stalls; results leave via
// the stage-one and output registers after the item that completes their
// window. The pipeline is: position logic and line-store read, window update
// and sum, output register. Both line stores share one read address, which
// sets the rate of one item per clock. Reset is synchronous and active low;
// line stores are not cleared. A stalled output holds the pipeline, but an
// input is still taken while the window stage is empty.
module neighbourhood_sum_3x3_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [nsum_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // [7:0] pixel
    input  wire logic                            i_s_axis_tuser,  // [0] is_drain
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic [nsum_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,  // [11:0] window_sum
    output logic                                 o_m_axis_tlast,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [nsum_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [nsum_pkg::CFG_W-1:0]      i_cfg_data
);
    import nsum_pkg::*;

    logic       accept;
    logic       s1_go;
    logic       s1_valid;
    t_item_ctrl s1;
    t_addr      rd_addr;
    t_pixel     pix;
    t_pixel     up;
    t_pixel     mid;
    logic       out_valid;
    t_sum       out_sum;
    logic       out_last;

    // Drain transactions enter the line stores as zero.
    assign pix             = i_s_axis_tuser ? '0 : i_s_axis_tdata[PIXEL_BITS-1:0];
    assign s1_go           = s1_valid && (!out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !s1_valid || s1_go;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    nsum_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_s1_go     (s1_go),
        .i_pix       (pix),
        .o_rd_addr   (rd_addr),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1)
    );

    nsum_line_mem u_line_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_addr),
        .i_pix      (pix),
        .i_s1_valid (s1_valid),
        .i_s1_go    (s1_go),
        .i_s1_addr  (s1.addr),
        .o_up       (up),
        .o_mid      (mid)
    );

    nsum_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_go     (s1_go),
        .i_s1        (s1),
        .i_up        (up),
        .i_mid       (mid),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (out_valid),
        .o_sum       (out_sum),
        .o_last      (out_last)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(out_sum);
    assign o_m_axis_tlast  = out_last;

endmodule
`default_nettype wire
